[hdl/mwd_pkg.sv]
package mwd_pkg;

    localparam int SAMPLE_COUNT = 16;
    localparam int ADC_BITS     = 12;
    localparam int SUM_W        = 16;
    localparam int AVG_SHIFT    = $clog2(SAMPLE_COUNT);
    localparam int BATT_DIVIDER = 2;

    localparam int PCT_W  = 7;
    localparam int BAND_W = 3;
    localparam int WAKE_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // shared divider: 32-bit dividend, 16-bit divisor, one quotient bit a cycle
    localparam int DIV_W       = 32;
    localparam int DVSR_W      = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int PCT_NUM_W   = ADC_BITS + 7;
    localparam int PCT_PRESHFT = DIV_W - PCT_NUM_W;

    localparam logic [DIV_CNT_W-1:0] MOD_STEPS = DIV_CNT_W'(DIV_W);
    localparam logic [DIV_CNT_W-1:0] PCT_STEPS = DIV_CNT_W'(PCT_NUM_W);

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    typedef enum logic [IDX_W-1:0] {
        REG_DRY_RAW       = 3'd0,
        REG_WET_RAW       = 3'd1,
        REG_BATT_VALID_MV = 3'd2,
        REG_BATT_LOW_MV   = 3'd3,
        REG_ALERT_DRY_PCT = 3'd4,
        REG_ALERT_WET_PCT = 3'd5,
        REG_HB_INTERVAL   = 3'd6,
        REG_REDRAW_DELTA  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_PCT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_cmd_t;

    function automatic logic [BAND_W-1:0] band_of(input logic [PCT_W-1:0] pct);
        logic [BAND_W-1:0] b;
        if (pct < 7'd20)
            b = 3'd0;
        else if (pct < 7'd40)
            b = 3'd1;
        else if (pct < 7'd70)
            b = 3'd2;
        else if (pct < 7'd90)
            b = 3'd3;
        else
            b = 3'd4;
        return b;
    endfunction

endpackage

[hdl/mwd_div.sv]
module mwd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mwd_pkg::div_cmd_t            cmd,
    input  logic [mwd_pkg::DIV_W-1:0]    dividend,
    input  logic [mwd_pkg::DVSR_W-1:0]   divisor,
    output logic                         busy,
    output logic [mwd_pkg::DIV_W-1:0]    quotient,
    output logic [mwd_pkg::DVSR_W-1:0]   remainder
);
    import mwd_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     acc_reg, acc_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DVSR_W-1:0]    dvsr_reg, dvsr_next;
    logic [DVSR_W:0]      trial;
    logic                 ge;

    // restoring step: dividend bits shift out the top, quotient bits in the bottom
    assign trial = {rem_reg, acc_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (cmd.start)
        begin
            cnt_next  = cmd.steps;
            acc_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            acc_next = {acc_reg[DIV_W-2:0], ge};
            if (ge)
                rem_next = DVSR_W'(trial - {1'b0, dvsr_reg});
            else
                rem_next = trial[DVSR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = acc_reg;
    assign remainder = rem_reg;

endmodule

[hdl/moisture_wake_decision.sv]
// channel  | handshake           | words
// ---------+---------------------+--------------------------------------------
// in       | in_valid / in_stall | moisture_sum, batt_tap_sum_mv
// out      | out_valid/out_stall | moisture_pct, status_band, supply_ok,
//          |                     | supply_low, alert, heartbeat, redraw, publish,
//          |                     | wake_number
// cfg      | cfg_we              | cfg_index, cfg_data
//
// in_stall is high from accept until the result is loaded into the output
// register: a 32-step wake-count modulo then a 19-step percent divide on one
// shared restoring divider, with state sequencing around them.
// The result goes to an output register, so the next word is taken while the
// result waits; a new result waits in the divider until out_stall lets the
// register go.
// Reset restores the calibration defaults and clears the wake count and drawn state.
module moisture_wake_decision (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mwd_pkg::SUM_W-1:0]      moisture_sum,
    input  logic [mwd_pkg::SUM_W-1:0]      batt_tap_sum_mv,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mwd_pkg::PCT_W-1:0]      moisture_pct,
    output logic [mwd_pkg::BAND_W-1:0]     status_band,
    output logic                           supply_ok,
    output logic                           supply_low,
    output logic                           alert,
    output logic                           heartbeat,
    output logic                           redraw,
    output logic                           publish,
    output logic [mwd_pkg::WAKE_W-1:0]     wake_number,
    input  logic                           cfg_we,
    input  logic [mwd_pkg::IDX_W-1:0]      cfg_index,
    input  logic [mwd_pkg::CFG_W-1:0]      cfg_data
);
    import mwd_pkg::*;

    // configuration
    logic [ADC_BITS-1:0] dry_reg, wet_reg;
    logic [12:0]         bvalid_reg, blow_reg;
    logic [PCT_W-1:0]    adry_reg, awet_reg, delta_reg;
    logic [15:0]         interval_reg;

    state_t state_reg, state_next;

    logic [SUM_W-1:0]  msum_reg, msum_next;
    logic [SUM_W-1:0]  bsum_reg, bsum_next;
    logic              hb_reg, hb_next;
    logic [WAKE_W-1:0] wake_reg, wake_next;
    logic              drawn_reg, drawn_next;
    logic [PCT_W-1:0]  last_pct_reg, last_pct_next;
    logic              last_alert_reg, last_alert_next;
    logic              last_low_reg, last_low_next;

    logic              ov_reg, ov_next;
    logic [PCT_W-1:0]  o_pct_reg, o_pct_next;
    logic [BAND_W-1:0] o_band_reg, o_band_next;
    logic              o_valid_reg, o_valid_next;
    logic              o_low_reg, o_low_next;
    logic              o_alert_reg, o_alert_next;
    logic              o_hb_reg, o_hb_next;
    logic              o_redraw_reg, o_redraw_next;
    logic              o_pub_reg, o_pub_next;
    logic [WAKE_W-1:0] o_wake_reg, o_wake_next;

    div_cmd_t          div_cmd;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVSR_W-1:0] div_divisor;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quo;
    logic [DVSR_W-1:0] div_rem;

    // percent map operands
    logic [ADC_BITS-1:0]  raw;
    logic                 num_neg, den_neg, pct_zero;
    logic [ADC_BITS-1:0]  num_mag, den_mag;
    logic [PCT_NUM_W-1:0] num_x100;
    logic [PCT_W-1:0]     pct;
    logic [BAND_W-1:0]    band;

    // battery
    logic [SUM_W:0] cell_scaled;
    logic           b_valid, b_low;

    logic           alert_c, redraw_c;
    logic [PCT_W-1:0] diff;
    logic           accept_in, out_free;
    logic [15:0]    interval_eff;

    mwd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (div_cmd),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign raw      = ADC_BITS'(msum_reg >> AVG_SHIFT);
    assign num_neg  = raw < dry_reg;
    assign den_neg  = wet_reg < dry_reg;
    assign num_mag  = num_neg ? dry_reg - raw : raw - dry_reg;
    assign den_mag  = den_neg ? dry_reg - wet_reg : wet_reg - dry_reg;
    // x100 = x64 + x32 + x4
    assign num_x100 = (PCT_NUM_W'(num_mag) << 6) + (PCT_NUM_W'(num_mag) << 5)
                    + (PCT_NUM_W'(num_mag) << 2);
    // negative quotient clamps to zero; equal points give zero
    assign pct_zero = (dry_reg == wet_reg) || (num_neg != den_neg);
    assign pct      = pct_zero ? '0
                    : (div_quo > DIV_W'(PCT_MAX)) ? PCT_MAX : div_quo[PCT_W-1:0];
    assign band     = band_of(pct);

    assign cell_scaled = (SUM_W+1)'(bsum_reg) * (SUM_W+1)'(BATT_DIVIDER);
    assign b_valid     = cell_scaled >= ((SUM_W+1)'(bvalid_reg) << AVG_SHIFT);
    assign b_low       = b_valid && (cell_scaled <= ((SUM_W+1)'(blow_reg) << AVG_SHIFT));

    assign alert_c = (pct < adry_reg) || (pct > awet_reg) || b_low;
    assign diff    = (pct >= last_pct_reg) ? pct - last_pct_reg : last_pct_reg - pct;

    always_comb
    begin
        if (!drawn_reg || hb_reg)
            redraw_c = 1'b1;
        else if (alert_c != last_alert_reg || b_low != last_low_reg)
            redraw_c = 1'b1;
        else
            redraw_c = (diff >= delta_reg) || (band != band_of(last_pct_reg));
    end

    assign interval_eff = (interval_reg == '0) ? 16'd1 : interval_reg;
    assign accept_in    = in_valid && (state_reg == ST_IDLE);
    assign out_free     = !ov_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        msum_next       = msum_reg;
        bsum_next       = bsum_reg;
        hb_next         = hb_reg;
        wake_next       = wake_reg;
        drawn_next      = drawn_reg;
        last_pct_next   = last_pct_reg;
        last_alert_next = last_alert_reg;
        last_low_next   = last_low_reg;
        ov_next         = ov_reg && out_stall;
        o_pct_next      = o_pct_reg;
        o_band_next     = o_band_reg;
        o_valid_next    = o_valid_reg;
        o_low_next      = o_low_reg;
        o_alert_next    = o_alert_reg;
        o_hb_next       = o_hb_reg;
        o_redraw_next   = o_redraw_reg;
        o_pub_next      = o_pub_reg;
        o_wake_next     = o_wake_reg;
        div_cmd.start   = 1'b0;
        div_cmd.steps   = MOD_STEPS;
        div_dividend    = wake_reg;
        div_divisor     = interval_eff;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    msum_next     = moisture_sum;
                    bsum_next     = batt_tap_sum_mv;
                    div_cmd.start = 1'b1;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (!div_busy)
                begin
                    hb_next       = div_rem == '0;
                    div_cmd.start = 1'b1;
                    div_cmd.steps = PCT_STEPS;
                    div_dividend  = {num_x100, {PCT_PRESHFT{1'b0}}};
                    div_divisor   = DVSR_W'(den_mag);
                    state_next    = ST_PCT;
                end
            end
            ST_PCT:
            begin
                if (!div_busy && out_free)
                begin
                    ov_next       = 1'b1;
                    o_pct_next    = pct;
                    o_band_next   = band;
                    o_valid_next  = b_valid;
                    o_low_next    = b_low;
                    o_alert_next  = alert_c;
                    o_hb_next     = hb_reg;
                    o_redraw_next = redraw_c;
                    o_pub_next    = alert_c || hb_reg;
                    o_wake_next   = wake_reg;
                    wake_next     = wake_reg + 1'b1;
                    if (redraw_c)
                    begin
                        drawn_next      = 1'b1;
                        last_pct_next   = pct;
                        last_alert_next = alert_c;
                        last_low_next   = b_low;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wake_reg       <= '0;
            drawn_reg      <= 1'b0;
            last_pct_reg   <= '0;
            last_alert_reg <= 1'b0;
            last_low_reg   <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wake_reg       <= wake_next;
            drawn_reg      <= drawn_next;
            last_pct_reg   <= last_pct_next;
            last_alert_reg <= last_alert_next;
            last_low_reg   <= last_low_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msum_reg     <= msum_next;
        bsum_reg     <= bsum_next;
        hb_reg       <= hb_next;
        o_pct_reg    <= o_pct_next;
        o_band_reg   <= o_band_next;
        o_valid_reg  <= o_valid_next;
        o_low_reg    <= o_low_next;
        o_alert_reg  <= o_alert_next;
        o_hb_reg     <= o_hb_next;
        o_redraw_reg <= o_redraw_next;
        o_pub_reg    <= o_pub_next;
        o_wake_reg   <= o_wake_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_reg      <= 12'd3160;
            wet_reg      <= 12'd1300;
            bvalid_reg   <= 13'd2500;
            blow_reg     <= 13'd3600;
            adry_reg     <= 7'd20;
            awet_reg     <= 7'd90;
            interval_reg <= 16'd48;
            delta_reg    <= 7'd3;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DRY_RAW:       dry_reg      <= cfg_data[ADC_BITS-1:0];
                REG_WET_RAW:       wet_reg      <= cfg_data[ADC_BITS-1:0];
                REG_BATT_VALID_MV: bvalid_reg   <= cfg_data[12:0];
                REG_BATT_LOW_MV:   blow_reg     <= cfg_data[12:0];
                REG_ALERT_DRY_PCT: adry_reg     <= cfg_data[PCT_W-1:0];
                REG_ALERT_WET_PCT: awet_reg     <= cfg_data[PCT_W-1:0];
                REG_HB_INTERVAL:   interval_reg <= cfg_data;
                REG_REDRAW_DELTA:  delta_reg    <= cfg_data[PCT_W-1:0];
                default:           dry_reg      <= dry_reg;
            endcase
        end
    end

    assign in_stall     = state_reg != ST_IDLE;
    assign out_valid    = ov_reg;
    assign moisture_pct = o_pct_reg;
    assign status_band  = o_band_reg;
    assign supply_ok    = o_valid_reg;
    assign supply_low   = o_low_reg;
    assign alert        = o_alert_reg;
    assign heartbeat    = o_hb_reg;
    assign redraw       = o_redraw_reg;
    assign publish      = o_pub_reg;
    assign wake_number  = o_wake_reg;

endmodule
